// ===== rtl/qrm_pkg.sv =====
// Shared types and constants for the quaternion to rotation matrix pipeline.
`default_nettype none
package qrm_pkg;

  // Q2.14 one
  localparam int unsigned QOne      = 16384;
  // matrix entries per item
  localparam int unsigned NumEnt    = 9;
  // width of the squared magnitude and the threshold
  localparam int unsigned NormW     = 33;
  // quotient bits: floor(|num| * 2^15 / n), at most 2^15
  localparam int unsigned QuoW      = 16;
  // restoring steps after the first compare
  localparam int unsigned DivSteps  = QuoW - 1;

  // Divider lane state carried down the pipeline
  typedef struct packed {
    logic [NormW-1:0]                n;
    logic [NumEnt-1:0]               neg;
    logic [NumEnt-1:0][NormW-1:0]    rem;
    logic [NumEnt-1:0][QuoW-1:0]     quo;
    logic                            degen;
  } qrm_div_t;

endpackage
`default_nettype wire

// ===== rtl/qrm_front.sv =====
// Front end: products, norm and numerators, magnitudes, first quotient bit.
`default_nettype none
module qrm_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [15:0]   comp_w,
  input  wire logic signed [15:0]   comp_x,
  input  wire logic signed [15:0]   comp_y,
  input  wire logic signed [15:0]   comp_z,
  input  wire logic [qrm_pkg::NormW-1:0] thresh,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output qrm_pkg::qrm_div_t         out_data
);

  // stage valids and readies
  logic v1, v2, v3, v4;
  logic r1, r2, r3, r4;

  assign r4 = !v4 || out_ready;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready  = r1;
  assign out_valid = v4;

  // stage 1: ten products
  logic signed [31:0] ww, xx, yy, zz, xy, zw, xz, yw, yz, xw;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= in_valid;
    end
    if (r1 && in_valid) begin
      ww <= comp_w * comp_w;
      xx <= comp_x * comp_x;
      yy <= comp_y * comp_y;
      zz <= comp_z * comp_z;
      xy <= comp_x * comp_y;
      zw <= comp_z * comp_w;
      xz <= comp_x * comp_z;
      yw <= comp_y * comp_w;
      yz <= comp_y * comp_z;
      xw <= comp_x * comp_w;
    end
  end

  // stage 2: norm and signed numerators (34 bits)
  logic [qrm_pkg::NormW-1:0]                      n2;
  logic [qrm_pkg::NumEnt-1:0][qrm_pkg::NormW:0]   num2;
  logic [qrm_pkg::NormW-1:0]                      n2_next;
  logic [qrm_pkg::NumEnt-1:0][qrm_pkg::NormW:0]   num2_next;
  logic signed [33:0] sw, sx, sy, sz, pxy, pzw, pxz, pyw, pyz, pxw;

  always_comb begin
    sw  = {{2{ww[31]}}, ww};
    sx  = {{2{xx[31]}}, xx};
    sy  = {{2{yy[31]}}, yy};
    sz  = {{2{zz[31]}}, zz};
    pxy = {{2{xy[31]}}, xy};
    pzw = {{2{zw[31]}}, zw};
    pxz = {{2{xz[31]}}, xz};
    pyw = {{2{yw[31]}}, yw};
    pyz = {{2{yz[31]}}, yz};
    pxw = {{2{xw[31]}}, xw};
    n2_next = {1'b0, ww} + {1'b0, xx} + {1'b0, yy} + {1'b0, zz};
    num2_next[0] = sw + sx - sy - sz;
    num2_next[1] = (pxy - pzw) <<< 1;
    num2_next[2] = (pxz + pyw) <<< 1;
    num2_next[3] = (pxy + pzw) <<< 1;
    num2_next[4] = sw - sx + sy - sz;
    num2_next[5] = (pyz - pxw) <<< 1;
    num2_next[6] = (pxz - pyw) <<< 1;
    num2_next[7] = (pyz + pxw) <<< 1;
    num2_next[8] = sw - sx - sy + sz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
    if (r2 && v1) begin
      n2   <= n2_next;
      num2 <= num2_next;
    end
  end

  // stage 3: degenerate test, sign and magnitude
  logic [qrm_pkg::NormW-1:0]                     n3;
  logic [qrm_pkg::NumEnt-1:0]                    neg3;
  logic [qrm_pkg::NumEnt-1:0][qrm_pkg::NormW-1:0] mag3;
  logic                                          degen3;
  logic [qrm_pkg::NumEnt-1:0][qrm_pkg::NormW:0]   negd;

  always_comb begin
    for (int i = 0; i < qrm_pkg::NumEnt; i++) begin
      negd[i] = -num2[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (r3) begin
      v3 <= v2;
    end
    if (r3 && v2) begin
      n3     <= n2;
      degen3 <= (n2 == '0) || (n2 < thresh);
      for (int i = 0; i < qrm_pkg::NumEnt; i++) begin
        neg3[i] <= num2[i][qrm_pkg::NormW];
        mag3[i] <= num2[i][qrm_pkg::NormW] ? negd[i][qrm_pkg::NormW-1:0]
                                           : num2[i][qrm_pkg::NormW-1:0];
      end
    end
  end

  // stage 4: top quotient bit (set only when |num| equals n)
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (r4) begin
      v4 <= v3;
    end
    if (r4 && v3) begin
      out_data.n     <= n3;
      out_data.neg   <= neg3;
      out_data.degen <= degen3;
      for (int i = 0; i < qrm_pkg::NumEnt; i++) begin
        if (mag3[i] >= n3) begin
          out_data.rem[i] <= mag3[i] - n3;
          out_data.quo[i] <= qrm_pkg::QuoW'(1);
        end else begin
          out_data.rem[i] <= mag3[i];
          out_data.quo[i] <= '0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/qrm_div_step.sv =====
// One restoring division step for all nine lanes, registered.
`default_nettype none
module qrm_div_step (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire qrm_pkg::qrm_div_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output qrm_pkg::qrm_div_t      out_data
);

  qrm_pkg::qrm_div_t data_next;
  logic [qrm_pkg::NormW:0] trial;

  assign in_ready = !out_valid || out_ready;

  // shift remainder, compare with n, subtract when it fits
  always_comb begin
    data_next = in_data;
    trial     = '0;
    for (int i = 0; i < qrm_pkg::NumEnt; i++) begin
      trial = {in_data.rem[i], 1'b0};
      if (trial >= {1'b0, in_data.n}) begin
        data_next.rem[i] = qrm_pkg::NormW'(trial - {1'b0, in_data.n});
        data_next.quo[i] = {in_data.quo[i][qrm_pkg::QuoW-2:0], 1'b1};
      end else begin
        data_next.rem[i] = trial[qrm_pkg::NormW-1:0];
        data_next.quo[i] = {in_data.quo[i][qrm_pkg::QuoW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/quaternion_to_rotation_matrix_top.sv =====
// Top level: quaternion to 3x3 rotation matrix, Q2.14 output, fully pipelined.
//
//   channel  dir  handshake              payload
//   s_axis   in   s_axis_tvalid/tready   tdata: comp_w, comp_x, comp_y, comp_z
//   m_axis   out  m_axis_tvalid/tready   tdata: m00..m22, tuser: degenerate
//   cfg      in   cfg_valid/cfg_ready    cfg_data: near_zero_threshold
//
// One quaternion accepted per cycle unless m_axis stalls; each passes four front
// stages, fifteen restoring steps (one quotient bit each) and the output stage.
// Every stage keeps its own valid and is loaded whenever it is empty or its
// successor moves, so a stall on m_axis fills bubbles before back-pressuring.
// Synchronous reset clears all valids and sets the threshold to one.
`default_nettype none
module quaternion_to_rotation_matrix_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // comp_w [15:0], comp_x [31:16], comp_y [47:32], comp_z [63:48]
  input  wire logic [63:0]   s_axis_tdata,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // m00 [15:0], m01, m02, m10, m11, m12, m20, m21, m22 [143:128]
  output logic [143:0]       m_axis_tdata,
  // degenerate [0]
  output logic [0:0]         m_axis_tuser,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [32:0]   cfg_data
);

  // threshold register
  logic [qrm_pkg::NormW-1:0] thresh;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= qrm_pkg::NormW'(1);
    end else if (cfg_valid) begin
      thresh <= cfg_data;
    end
  end

  // front end
  logic               sv [0:qrm_pkg::DivSteps];
  logic               sr [0:qrm_pkg::DivSteps];
  qrm_pkg::qrm_div_t  sd [0:qrm_pkg::DivSteps];

  qrm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .comp_w    (s_axis_tdata[15:0]),
    .comp_x    (s_axis_tdata[31:16]),
    .comp_y    (s_axis_tdata[47:32]),
    .comp_z    (s_axis_tdata[63:48]),
    .thresh    (thresh),
    .out_valid (sv[0]),
    .out_ready (sr[0]),
    .out_data  (sd[0])
  );

  // divider chain
  for (genvar g = 0; g < qrm_pkg::DivSteps; g++) begin : g_div
    qrm_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sv[g]),
      .in_ready  (sr[g]),
      .in_data   (sd[g]),
      .out_valid (sv[g+1]),
      .out_ready (sr[g+1]),
      .out_data  (sd[g+1])
    );
  end

  // output stage: round half up on the doubled quotient, clamp, sign, identity
  qrm_pkg::qrm_div_t               fin;
  logic [143:0]                    tdata_next;
  logic [qrm_pkg::QuoW:0]          rnd;
  logic [qrm_pkg::QuoW-1:0]        mag;

  assign fin = sd[qrm_pkg::DivSteps];
  assign sr[qrm_pkg::DivSteps] = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    tdata_next = '0;
    rnd        = '0;
    mag        = '0;
    for (int i = 0; i < qrm_pkg::NumEnt; i++) begin
      rnd = {1'b0, fin.quo[i]} + (qrm_pkg::QuoW+1)'(1);
      mag = rnd[qrm_pkg::QuoW:1];
      if (mag > qrm_pkg::QuoW'(qrm_pkg::QOne)) begin
        mag = qrm_pkg::QuoW'(qrm_pkg::QOne);
      end
      if (fin.degen) begin
        tdata_next[i*16 +: 16] = (i % 4 == 0) ? 16'(qrm_pkg::QOne) : 16'd0;
      end else begin
        tdata_next[i*16 +: 16] = fin.neg[i] ? -mag : mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (sr[qrm_pkg::DivSteps]) begin
      m_axis_tvalid <= sv[qrm_pkg::DivSteps];
    end
    if (sr[qrm_pkg::DivSteps] && sv[qrm_pkg::DivSteps]) begin
      m_axis_tdata    <= tdata_next;
      m_axis_tuser[0] <= fin.degen;
    end
  end

`ifndef SYNTHESIS
  // identity result when flagged
  a_degen_identity: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata[15:0] == 16'd16384 && m_axis_tdata[31:16] == 16'd0 &&
      m_axis_tdata[143:128] == 16'd16384)
    else $error("degenerate result is not the identity");

  // m00 stays within plus or minus one
  a_m00_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      $signed(m_axis_tdata[15:0]) <= 16384 && $signed(m_axis_tdata[15:0]) >= -16384)
    else $error("m00 out of range");

  // threshold takes the written value
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> thresh == $past(cfg_data))
    else $error("threshold write lost");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for the quaternion to rotation matrix pipeline: random and directed quaternions.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] cz;
    logic signed [15:0] cy;
    logic signed [15:0] cx;
    logic signed [15:0] cw;
  } quat_t;

  typedef struct {
    logic [143:0] mat;
    logic         degen;
  } matrix_t;

  localparam int unsigned DrainCycles = 40;
  localparam int unsigned StallLimit  = 2000;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [63:0]   s_axis_tdata = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [143:0]  m_axis_tdata;
  logic [0:0]    m_axis_tuser;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [32:0]   cfg_data = '0;

  quaternion_to_rotation_matrix_top uut (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  quat_t       quat_q[$];
  matrix_t     matrix_q[$];
  logic [32:0] thresh_model;
  int          fails = 0;
  int          quiet_cycles = 0;

  // round(16384*num/n), ties away from zero, clamped to one
  function automatic logic [15:0] q14_div(longint num, longint unsigned n);
    longint unsigned mag, quo;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    quo = (2 * mag * qrm_pkg::QOne + n) / (2 * n);
    if (quo > qrm_pkg::QOne) quo = qrm_pkg::QOne;
    return (num < 0) ? 16'(-longint'(quo)) : 16'(quo);
  endfunction

  function automatic matrix_t rotation_of(quat_t q);
    matrix_t r;
    longint w, x, y, z, ww, xx, yy, zz;
    longint unsigned n;
    w = q.cw; x = q.cx; y = q.cy; z = q.cz;
    ww = w*w; xx = x*x; yy = y*y; zz = z*z;
    n = ww + xx + yy + zz;
    if (n == 0 || n < thresh_model) begin
      r.mat = '0;
      r.mat[15:0]    = 16'(qrm_pkg::QOne);
      r.mat[79:64]   = 16'(qrm_pkg::QOne);
      r.mat[143:128] = 16'(qrm_pkg::QOne);
      r.degen = 1'b1;
      return r;
    end
    r.mat[15:0]    = q14_div(longint'(n) - 2*(yy+zz), n);
    r.mat[31:16]   = q14_div(2*(x*y - z*w), n);
    r.mat[47:32]   = q14_div(2*(x*z + y*w), n);
    r.mat[63:48]   = q14_div(2*(x*y + z*w), n);
    r.mat[79:64]   = q14_div(longint'(n) - 2*(xx+zz), n);
    r.mat[95:80]   = q14_div(2*(y*z - x*w), n);
    r.mat[111:96]  = q14_div(2*(x*z - y*w), n);
    r.mat[127:112] = q14_div(2*(y*z + x*w), n);
    r.mat[143:128] = q14_div(longint'(n) - 2*(xx+yy), n);
    r.degen = 1'b0;
    return r;
  endfunction

  // ready as seen at the last rising edge
  logic s_axis_tready_s = 1'b0;
  always @(posedge clk) s_axis_tready_s <= s_axis_tready;

  // Source driver: random gap before each transaction
  int src_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready_s) begin
        quat_q.pop_front();
        src_gap = $urandom_range(0, 8);
      end
      if (s_axis_tvalid && !s_axis_tready_s) begin
        // hold current transaction
      end else if (quat_q.size() > 0 && src_gap == 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= quat_q[0];
      end else begin
        s_axis_tvalid <= 1'b0;
        if (src_gap > 0) src_gap--;
      end
    end
  end

  // Sink stall: random wait per result
  int snk_gap = 0;
  logic out_taken = 1'b0;
  always @(negedge clk) begin
    if (!rst) begin
      if (out_taken) snk_gap = $urandom_range(0, 8);
      if (snk_gap > 0) begin
        m_axis_tready <= 1'b0;
        snk_gap--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: check each result transaction against the oldest prediction
  always @(posedge clk) begin
    matrix_t exp_m;
    out_taken <= !rst && m_axis_tvalid && m_axis_tready;
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (s_axis_tvalid && s_axis_tready)
        matrix_q.push_back(rotation_of(quat_t'(s_axis_tdata)));
      if (m_axis_tvalid && m_axis_tready) begin
        if (matrix_q.size() == 0) begin
          $display("%0t: unexpected result %h deg %b", $time, m_axis_tdata, m_axis_tuser);
          fails++;
        end else begin
          exp_m = matrix_q.pop_front();
          for (int e = 0; e < qrm_pkg::NumEnt; e++)
            if (m_axis_tdata[16*e +: 16] !== exp_m.mat[16*e +: 16]) begin
              $display("%0t: entry %0d expected %0d actual %0d", $time, e,
                       $signed(exp_m.mat[16*e +: 16]), $signed(m_axis_tdata[16*e +: 16]));
              fails++;
            end
          if (m_axis_tuser[0] !== exp_m.degen) begin
            $display("%0t: degenerate expected %b actual %b", $time, exp_m.degen,
                     m_axis_tuser[0]);
            fails++;
          end
        end
      end
      if (quiet_cycles >= StallLimit) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 6)) - 16'sd3;
      3: return 16'($urandom_range(0, 512)) - 16'sd256;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_quat(int w, int x, int y, int z);
    quat_t q;
    q.cw = 16'(w); q.cx = 16'(x); q.cy = 16'(y); q.cz = 16'(z);
    quat_q.push_back(q);
  endtask

  // wait until every prediction is met, then let the pipeline settle
  task automatic drain();
    wait (quat_q.size() == 0 && !s_axis_tvalid);
    wait (matrix_q.size() == 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_threshold(logic [32:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    thresh_model = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_batch(int count);
    for (int k = 0; k < count; k++)
      add_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
  endtask

  initial begin
    logic [32:0] settings[5];
    thresh_model = 33'd1;
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: zero quaternion, extremes, unit axes, below-threshold cases
    add_quat(0, 0, 0, 0);
    add_quat(1, 0, 0, 0);
    add_quat(0, 1, 0, 0);
    add_quat(0, 0, 1, 0);
    add_quat(0, 0, 0, 1);
    add_quat(32767, 32767, 32767, 32767);
    add_quat(-32768, -32768, -32768, -32768);
    add_quat(-32768, 32767, -32768, 32767);
    add_quat(16384, 0, 0, 16384);
    add_quat(1, 1, 1, 1);
    add_quat(-1, 2, -3, 4);
    add_quat(3, 0, 0, 1);
    add_quat(100, -200, 300, -400);
    add_quat(32767, -32768, 0, 1);
    drain();

    // zero threshold: zero magnitude must still give the identity
    write_threshold(33'd0);
    add_quat(0, 0, 0, 0);
    add_quat(0, 0, 0, -1);
    add_quat(5, 5, 5, 5);
    random_batch(200);
    drain();

    settings[0] = 33'h1FFFFFFFF;
    settings[1] = 33'h100000000;
    settings[2] = 33'd30;
    settings[3] = 33'($urandom);
    settings[4] = 33'd65536;
    foreach (settings[s]) begin
      write_threshold(settings[s]);
      add_quat(-32768, -32768, -32768, -32768);
      add_quat(2, 3, 1, 4);
      random_batch(200);
      drain();
    end

    if (fails == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== quaternion_to_rotation_matrix_top.f =====
rtl/qrm_pkg.sv
rtl/qrm_front.sv
rtl/qrm_div_step.sv
rtl/quaternion_to_rotation_matrix_top.sv
tb/sv/tb.sv
